>>> src/diff_drive_wheel_speeds_assert.svh
// assertion macros for the wheel speed block
`ifndef DIFF_DRIVE_WHEEL_SPEEDS_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_SPEEDS_ASSERT_SVH

// implication checked every edge outside reset
`define DDWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle
`define DDWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ddws_pkg.sv
`timescale 1ns / 1ps
package ddws_pkg;
  localparam int CordicSteps = 16;
  localparam int SpeedWidth  = 16;
  localparam int CW          = 34;  // cordic x/y width
  localparam int ZW          = 26;  // angle accumulator width
  localparam int QDepth      = 4;
  localparam int QAw         = 2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SOFT = 2'd1;
  localparam logic [1:0] MODE_HARD = 2'd2;

  localparam logic [1:0] REG_TOP_SPEED  = 2'd0;
  localparam logic [1:0] REG_NO_TURN    = 2'd1;
  localparam logic [1:0] REG_SPIN_LIMIT = 2'd2;

  localparam logic [31:0] InvGain = 32'd2608131497;

  function automatic logic [ZW-1:0] atan_lut(input int i);
    logic [ZW-1:0] t [24];
    t = '{26'd2097152, 26'd1238021, 26'd654136, 26'd332050, 26'd166669, 26'd83416,
          26'd41718, 26'd20860, 26'd10430, 26'd5215, 26'd2608, 26'd1304, 26'd652,
          26'd326, 26'd163, 26'd81, 26'd41, 26'd20, 26'd10, 26'd5, 26'd3, 26'd1,
          26'd1, 26'd0};
    return t[i];
  endfunction

  // word passed from the cordic front to the speed back end
  typedef struct packed {
    logic signed [17:0] angle;
    logic [16:0]        len;
  } ddws_word_t;
endpackage

>>> src/diff_drive_wheel_speeds.sv
`timescale 1ns / 1ps
// path: start to out_valid runs through the cordic front, then the queue, then the speed stages
// throughput: one word per cycle, start may be high every cycle; busy stays low
// cordic stages and a pipelined restoring divider set the latency
// reset: synchronous active-low rst_n clears valids, queue and restores registers
// the receiver cannot stall; each result is shown for one cycle on out_valid
module diff_drive_wheel_speeds (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_heading_x,
  input  logic signed [15:0] in_heading_y,
  output logic               out_valid,
  output logic signed [17:0] out_left_speed,
  output logic signed [17:0] out_right_speed,
  output logic [1:0]         out_turn_mode,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import ddws_pkg::*;

  logic [15:0] top_speed_r, no_turn_r, spin_limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r <= 16'd2560; no_turn_r <= 16'd1820; spin_limit_r <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOP_SPEED:  top_speed_r  <= cfg_data;
        REG_NO_TURN:    no_turn_r    <= cfg_data;
        REG_SPIN_LIMIT: spin_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic       f_valid, q_ne;
  ddws_word_t f_word, q_head;

  ddws_front u_front (
    .clk, .rst_n, .in_valid(start && !busy), .in_x(in_heading_x), .in_y(in_heading_y),
    .out_valid(f_valid), .out_word(f_word)
  );

  // back end never stalls, so the queue drains every cycle
  ddws_queue u_queue (
    .clk, .rst_n, .push(f_valid), .push_word(f_word), .pop(q_ne),
    .not_empty(q_ne), .head(q_head)
  );

  ddws_back u_back (
    .clk, .rst_n, .in_valid(q_ne), .in_word(q_head),
    .top_speed(top_speed_r), .no_turn(no_turn_r), .spin_limit(spin_limit_r),
    .out_valid, .out_left(out_left_speed), .out_right(out_right_speed),
    .out_mode(out_turn_mode)
  );
endmodule

>>> src/ddws_front.sv
`timescale 1ns / 1ps
module ddws_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [15:0]   in_x,
  input  logic signed [15:0]   in_y,
  output logic                 out_valid,
  output ddws_pkg::ddws_word_t out_word
);
  import ddws_pkg::*;

  logic signed [CW-1:0] x_r [CordicSteps+1];
  logic signed [CW-1:0] y_r [CordicSteps+1];
  logic signed [ZW-1:0] z_r [CordicSteps+1];
  logic signed [15:0]   hx_r [CordicSteps+1];
  logic signed [15:0]   hy_r [CordicSteps+1];
  logic [CordicSteps:0] v_r;

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;

  // quarter-turn fold into the right half plane
  always_comb begin
    x0 = CW'(in_x) <<< 14;
    y0 = CW'(in_y) <<< 14;
    z0 = '0;
    if (in_x < 0) begin
      if (in_y > 0) begin
        x0 = CW'(in_y) <<< 14;
        y0 = -(CW'(in_x) <<< 14);
        z0 = ZW'(4194304);
      end else begin
        x0 = -(CW'(in_y) <<< 14);
        y0 = CW'(in_x) <<< 14;
        z0 = -ZW'(4194304);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[CordicSteps-1:0], in_valid};
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x0; y_r[0] <= y0; z_r[0] <= z0;
    hx_r[0] <= in_x; hy_r[0] <= in_y;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    always_ff @(posedge clk) begin
      hx_r[i+1] <= hx_r[i];
      hy_r[i+1] <= hy_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_lut(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_lut(i);
      end
    end
  end

  logic signed [ZW-1:0] zr;
  logic signed [17:0]   ang;
  logic signed [15:0]   hx, hy;
  logic signed [CW-1:0] xf;
  logic [63:0]          prod;

  always_comb begin
    hx  = hx_r[CordicSteps];
    hy  = hy_r[CordicSteps];
    xf  = x_r[CordicSteps];
    zr  = (z_r[CordicSteps] + ZW'(128)) >>> 8;
    ang = 18'(zr);
    if (zr > ZW'(32768)) ang = 18'sd32768;
    if (zr < -ZW'(32768)) ang = -18'sd32768;
    if (hy == 0) ang = (hx < 0) ? 18'sd32768 : 18'sd0;
    else if (hy > 0 && ang < 1) ang = 18'sd1;
    else if (hy < 0 && ang > -1) ang = -18'sd1;
    prod = (xf > 0) ? 64'(unsigned'(xf[31:0])) * 64'(InvGain) : 64'd0;
  end

  always_ff @(posedge clk) begin
    out_word.angle <= ang;
    out_word.len   <= 17'((prod + (64'd1 << 45)) >> 46);
  end

  // valid follows the registered word
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v_r[CordicSteps];
  end
endmodule

>>> src/ddws_queue.sv
`timescale 1ns / 1ps
module ddws_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ddws_pkg::ddws_word_t push_word,
  input  logic                 pop,
  output logic                 not_empty,
  output ddws_pkg::ddws_word_t head
);
  import ddws_pkg::*;
  `include "diff_drive_wheel_speeds_assert.svh"

  ddws_word_t   mem_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_word;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end
  assign not_empty = cnt_r != 0;
  assign head = mem_r[rp_r];

  `DDWS_ASSERT_IMP(a_no_overflow, push && !pop, cnt_r < (QAw+1)'(QDepth), "queue overflow")
  `DDWS_ASSERT_IMP(a_no_underflow, pop, cnt_r != 0, "queue underflow")
  `DDWS_ASSERT_NXT(a_cnt_keep, push && pop, cnt_r == $past(cnt_r), "queue count drift")
endmodule

>>> src/ddws_back.sv
`timescale 1ns / 1ps
module ddws_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ddws_pkg::ddws_word_t in_word,
  input  logic [15:0]          top_speed,
  input  logic [15:0]          no_turn,
  input  logic [15:0]          spin_limit,
  output logic                 out_valid,
  output logic signed [17:0]   out_left,
  output logic signed [17:0]   out_right,
  output logic [1:0]           out_mode
);
  import ddws_pkg::*;

  // stage 1: classify, multiply numerator
  logic [16:0] a, base;
  logic [15:0] maxs;
  logic [1:0]  mode;
  logic        pos;
  assign maxs = 16'(top_speed[SpeedWidth-1:0]);
  always_comb begin
    a    = in_word.angle[17] ? 17'(-in_word.angle) : 17'(in_word.angle);
    base = (in_word.len < 17'(maxs)) ? in_word.len : 17'(maxs);
    if (a <= 17'(no_turn)) mode = MODE_NONE;
    else if (a > 17'(spin_limit) || spin_limit == 0) mode = MODE_HARD;
    else mode = MODE_SOFT;
  end
  assign pos = ~in_word.angle[17] && in_word.angle != 0;

  logic [15:0] diff;
  assign diff = 16'(17'(spin_limit) - a);

  // restoring divider pipeline, one quotient bit per stage
  localparam int QB = 17;
  logic        vd_r [QB+1];
  logic [1:0]  md_r [QB+1];
  logic        pd_r [QB+1];
  logic [16:0] bd_r [QB+1];
  logic [15:0] sd_r [QB+1];
  logic [16:0] dd_r [QB+1];
  logic [33:0] rem_r [QB+1];
  logic [16:0] q_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r[0] <= 1'b0;
    else vd_r[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    md_r[0] <= mode; pd_r[0] <= pos; bd_r[0] <= base; sd_r[0] <= maxs;
    dd_r[0]  <= {spin_limit, 1'b0};
    rem_r[0] <= 34'({base, 1'b0}) * 34'(diff) + 34'(spin_limit);
    q_r[0]   <= '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int Sh = QB - 1 - k;
    logic [50:0] trial;
    assign trial = 51'(dd_r[k]) << Sh;
    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[k+1] <= 1'b0;
      else vd_r[k+1] <= vd_r[k];
    end
    always_ff @(posedge clk) begin
      md_r[k+1] <= md_r[k]; pd_r[k+1] <= pd_r[k]; bd_r[k+1] <= bd_r[k];
      sd_r[k+1] <= sd_r[k]; dd_r[k+1] <= dd_r[k];
      if (51'(rem_r[k]) >= trial) begin
        rem_r[k+1] <= 34'(51'(rem_r[k]) - trial);
        q_r[k+1]   <= q_r[k] | (17'd1 << Sh);
      end else begin
        rem_r[k+1] <= rem_r[k];
        q_r[k+1]   <= q_r[k];
      end
    end
  end

  logic signed [18:0] slow, fast;
  always_comb begin
    unique case (md_r[QB])
      MODE_NONE: begin
        slow = 19'(bd_r[QB]); fast = 19'(bd_r[QB]);
      end
      MODE_HARD: begin
        slow = -19'(sd_r[QB]); fast = 19'(sd_r[QB]);
      end
      default: begin
        slow = 19'(q_r[QB]); fast = 19'({bd_r[QB], 1'b0}) - 19'(q_r[QB]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vd_r[QB];
  end
  always_ff @(posedge clk) begin
    out_left  <= pd_r[QB] ? slow[17:0] : fast[17:0];
    out_right <= pd_r[QB] ? fast[17:0] : slow[17:0];
    out_mode  <= md_r[QB];
  end
endmodule

>>> bench/diff_drive_wheel_speeds_tb.sv
`timescale 1ns / 1ps
module diff_drive_wheel_speeds_tb;
  import ddws_pkg::*;

  typedef struct {
    logic signed [15:0] hx;
    logic signed [15:0] hy;
  } heading_t;

  typedef struct {
    logic signed [17:0] left;
    logic signed [17:0] right;
    logic [1:0]         mode;
  } wheels_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_heading_x;
  logic signed [15:0] in_heading_y;
  logic               out_valid;
  logic signed [17:0] out_left_speed;
  logic signed [17:0] out_right_speed;
  logic [1:0]         out_turn_mode;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  diff_drive_wheel_speeds dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_heading_x(in_heading_x), .in_heading_y(in_heading_y),
    .out_valid(out_valid), .out_left_speed(out_left_speed),
    .out_right_speed(out_right_speed), .out_turn_mode(out_turn_mode),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  heading_t  pending_q[$];
  wheels_t   expected_q[$];
  int        errors;
  longint    cycles;
  bit        sender_quiet;
  bit        hold_off;
  logic [15:0] max_spd, no_turn, spin_lim;

  localparam longint CycleLimit = 400000;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic wheels_t wheel_speeds(heading_t h);
    longint x, y, z, t, xs, ys, ang, slow, fast, l, r;
    longint unsigned len, base, a, maxs, hd, s, prod;
    wheels_t w;
    x = longint'(h.hx) * 16384;
    y = longint'(h.hy) * 16384;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = 4194304;
      end else begin
        x = -y; y = t; z = -4194304;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_lut(i));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_lut(i));
      end
    end
    ang = floor_shr(z + 128, 8);
    if (ang > 32768) ang = 32768;
    if (ang < -32768) ang = -32768;
    if (h.hy == 0) ang = (h.hx < 0) ? 32768 : 0;
    else if (h.hy > 0 && ang < 1) ang = 1;
    else if (h.hy < 0 && ang > -1) ang = -1;
    if (x > 0) begin
      prod = longint'(x) * longint'(InvGain);
      len = (prod + (64'd1 << 45)) >> 46;
    end else begin
      len = 0;
    end
    maxs = max_spd;
    base = (len < maxs) ? len : maxs;
    a = (ang < 0) ? -ang : ang;
    if (a <= no_turn) begin
      w.mode = MODE_NONE; slow = base; fast = base;
    end else if (a > spin_lim || spin_lim == 0) begin
      w.mode = MODE_HARD; slow = -longint'(maxs); fast = maxs;
    end else begin
      hd = spin_lim;
      s = (2 * base * (hd - a) + hd) / (2 * hd);
      w.mode = MODE_SOFT; slow = s; fast = 2 * base - s;
    end
    if (ang > 0) begin
      l = slow; r = fast;
    end else begin
      l = fast; r = slow;
    end
    w.left = l[17:0];
    w.right = r[17:0];
    return w;
  endfunction

  // driver: one word per accepted start, random gaps
  always @(negedge clk) begin
    if (!rst_n || hold_off || pending_q.size() == 0 ||
        (!sender_quiet && $urandom_range(99) < 12)) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_heading_x <= pending_q[0].hx;
      in_heading_y <= pending_q[0].hy;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      expected_q.push_back(wheel_speeds('{in_heading_x, in_heading_y}));
      void'(pending_q.pop_front());
    end
  end

  // monitor
  always @(posedge clk) begin
    wheels_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: left %0d right %0d mode %0d",
               out_left_speed, out_right_speed, out_turn_mode);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_left_speed !== e.left) begin
          $error("left_speed expected %0d got %0d", e.left, out_left_speed);
          errors++;
        end
        if (out_right_speed !== e.right) begin
          $error("right_speed expected %0d got %0d", e.right, out_right_speed);
          errors++;
        end
        if (out_turn_mode !== e.mode) begin
          $error("turn_mode expected %0d got %0d", e.mode, out_turn_mode);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TOP_SPEED: max_spd = val;
      REG_NO_TURN:   no_turn = val;
      default:       spin_lim = val;
    endcase
  endtask

  task automatic push(int x, int y);
    heading_t h;
    h.hx = x[15:0];
    h.hy = y[15:0];
    pending_q.push_back(h);
  endtask

  // mostly modest vectors, with full-range ones and axis cases mixed in
  task automatic push_random(int n);
    int x, y, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 5) begin
        x = $urandom_range(8191) - 4096;
        y = $urandom_range(8191) - 4096;
      end else if (k < 8) begin
        x = $urandom_range(65535);
        y = $urandom_range(65535);
      end else if (k == 8) begin
        x = $urandom_range(65535);
        y = 0;
      end else begin
        x = $urandom_range(255) - 128;
        y = $urandom_range(65535);
      end
      push(x, y);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    sender_quiet = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_heading_x = '0;
    in_heading_y = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TOP_SPEED;
    cfg_data = '0;
    max_spd = 16'd2560;
    no_turn = 16'd1820;
    spin_lim = 16'd16384;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero, axes, diagonals, extremes
    push(0, 0);
    push(32767, 0);
    push(-32768, 0);
    push(-1, 0);
    push(0, 32767);
    push(0, -32768);
    push(-32768, -32768);
    push(32767, 32767);
    push(-32768, 32767);
    push(32767, -32768);
    push(1, 1);
    push(-1, 1);
    push(-1, -1);
    push(2560, 300);
    push(2560, -300);
    push(1000, 800);
    push(-1000, 1);
    push(-1000, -1);
    push(5, -32768);
    push(-21846, 21845);
    drain();

    // pause until every word is back, then resume
    push_random(100);
    while (pending_q.size() > 50) @(posedge clk);
    hold_off = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    hold_off = 1'b0;
    drain();

    write_reg(REG_TOP_SPEED, 16'hFFFF);
    write_reg(REG_NO_TURN, 16'd0);
    write_reg(REG_SPIN_LIMIT, 16'd32768);
    push_random(300);
    drain();

    write_reg(REG_TOP_SPEED, 16'd0);
    write_reg(REG_NO_TURN, 16'd32768);
    write_reg(REG_SPIN_LIMIT, 16'd1);
    push_random(150);
    drain();

    // limits out of order, then zero hard limit
    write_reg(REG_TOP_SPEED, 16'd1000);
    write_reg(REG_NO_TURN, 16'd20000);
    write_reg(REG_SPIN_LIMIT, 16'd5000);
    push_random(150);
    drain();
    write_reg(REG_SPIN_LIMIT, 16'd0);
    write_reg(REG_NO_TURN, 16'd100);
    push_random(100);
    drain();

    // limits above half a turn, bit toggles on the config data
    write_reg(REG_NO_TURN, 16'hFFFF);
    write_reg(REG_SPIN_LIMIT, 16'hFFFF);
    write_reg(REG_TOP_SPEED, 16'h5555);
    push_random(100);
    drain();

    write_reg(REG_TOP_SPEED, 16'd2560);
    write_reg(REG_NO_TURN, 16'd1820);
    write_reg(REG_SPIN_LIMIT, 16'd16384);
    sender_quiet = 1'b1;
    push_random(250);
    drain();
    sender_quiet = 1'b0;
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_TOP_SPEED, 16'($urandom_range(65535)));
      write_reg(REG_NO_TURN, 16'($urandom_range(8000)));
      write_reg(REG_SPIN_LIMIT, 16'($urandom_range(32768, 1)));
      push_random(120);
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
